@@ hw/rtl/assert_macros.svh @@
// Assertion helper macros used by the reply parser RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a condition is followed by a consequence on the next clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/fpasv_pkg.sv @@
// Types and constants for the FTP passive-mode reply parser.
package fpasv_pkg;

	localparam int PREFIX_TEXT_LEN = 26;
	localparam int PREFIX_LENGTH = 26;
	localparam int PREFIX_LEN_EFF = (PREFIX_LENGTH < 1) ? 1 :
		((PREFIX_LENGTH > PREFIX_TEXT_LEN) ? PREFIX_TEXT_LEN : PREFIX_LENGTH);

	localparam int POS_W = 5;
	localparam logic [POS_W-1:0] PREFIX_LEN_W = POS_W'(PREFIX_LEN_EFF);

	// "227 Entering Passive Mode "
	localparam logic [7:0] PREFIX_TEXT [PREFIX_TEXT_LEN] = '{
		8'h32, 8'h32, 8'h37, 8'h20, 8'h45, 8'h6E, 8'h74, 8'h65, 8'h72,
		8'h69, 8'h6E, 8'h67, 8'h20, 8'h50, 8'h61, 8'h73, 8'h73, 8'h69,
		8'h76, 8'h65, 8'h20, 8'h4D, 8'h6F, 8'h64, 8'h65, 8'h20
	};

	localparam logic [7:0] CHAR_TWO   = 8'h32;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_CLOSE = 8'h29;

	localparam int NUM_COUNT = 6;
	localparam int CNT_W = 3;
	localparam logic [CNT_W-1:0] COUNTER_INIT = 3'd1;
	localparam logic [CNT_W-1:0] COUNTER_LAST = 3'd6;
	localparam logic [CNT_W-1:0] COUNTER_MAX  = 3'd7;
	localparam logic [11:0] NUM_SAT_LIMIT = 12'd255;

	typedef struct packed {
		logic [7:0] reply_byte;
		logic       restart;
	} byte_req_t;

	typedef struct packed {
		logic [31:0] host_address;
		logic [15:0] data_port;
		logic        field_overflow;
	} pasv_rsp_t;

endpackage

@@ hw/rtl/ftp_passive_reply_parser.sv @@
// FTP passive-mode reply parser: prefix matcher, number collector and result register.
//
//  channel  | valid       | stall       | payload                      | dir
//  byte     | byte_valid  | byte_stall  | byte_item (fpasv_pkg::byte_req_t) | in
//  pasv     | pasv_valid  | pasv_stall  | pasv_item (fpasv_pkg::pasv_rsp_t) | out
//
// One byte per cycle while the result is not stalled: a request enters the input
// register, then the matcher/collector logic updates the parser state and loads the
// result register.
// Reset clears the parser to prefix search with all six numbers zero.
// A stalled result holds the result register; the input register then holds too,
// and byte_stall rises only while both are full and the result is stalled.
module ftp_passive_reply_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  fpasv_pkg::byte_req_t  byte_item,
	output logic                  pasv_valid,
	input  logic                  pasv_stall,
	output fpasv_pkg::pasv_rsp_t  pasv_item
);

	logic                  valid_s1;
	fpasv_pkg::byte_req_t  req_s1;
	logic                  pasv_valid_q;
	fpasv_pkg::pasv_rsp_t  pasv_item_q;

	logic [fpasv_pkg::POS_W-1:0] match_position_q;
	logic                        collecting_q;
	logic [fpasv_pkg::CNT_W-1:0] number_counter_q;
	logic [7:0]                  number_values_q [fpasv_pkg::NUM_COUNT];
	logic                        overflow_seen_q;

	// state after an optional restart
	logic [fpasv_pkg::POS_W-1:0] mp_cur;
	logic                        col_cur;
	logic [fpasv_pkg::CNT_W-1:0] cnt_cur;
	logic [7:0]                  vals_cur [fpasv_pkg::NUM_COUNT];
	logic                        ovf_cur;

	// next state
	logic [fpasv_pkg::POS_W-1:0] mp_d;
	logic                        col_d;
	logic [fpasv_pkg::CNT_W-1:0] cnt_d;
	logic [7:0]                  vals_d [fpasv_pkg::NUM_COUNT];
	logic                        ovf_d;

	logic [fpasv_pkg::POS_W-1:0] pos;
	logic [fpasv_pkg::POS_W-1:0] pos_inc;
	logic [fpasv_pkg::CNT_W-1:0] cnt_idx;
	logic [7:0]                  ch;
	logic [11:0]                 num_sum;
	logic                        emit;
	fpasv_pkg::pasv_rsp_t        rsp_d;

	logic out_free;
	logic proc;

	assign out_free   = !pasv_valid_q || !pasv_stall;
	assign proc       = valid_s1 && out_free;
	assign byte_stall = valid_s1 && !out_free;
	assign pasv_valid = pasv_valid_q;
	assign pasv_item  = pasv_item_q;

	assign ch      = req_s1.reply_byte;
	assign cnt_idx = cnt_cur - fpasv_pkg::COUNTER_INIT;

	always_comb begin
		mp_cur   = match_position_q;
		col_cur  = collecting_q;
		cnt_cur  = number_counter_q;
		vals_cur = number_values_q;
		ovf_cur  = overflow_seen_q;
		if (req_s1.restart) begin
			mp_cur   = '0;
			col_cur  = 1'b0;
			cnt_cur  = fpasv_pkg::COUNTER_INIT;
			vals_cur = '{default: 8'h00};
			ovf_cur  = 1'b0;
		end

		pos     = (mp_cur >= fpasv_pkg::PREFIX_LEN_W) ? '0 : mp_cur;
		pos_inc = pos + fpasv_pkg::POS_W'(1);
		num_sum = 12'({vals_cur[cnt_idx], 3'b000}) + 12'({vals_cur[cnt_idx], 1'b0})
			+ 12'(ch[3:0]);

		rsp_d.host_address   = {vals_cur[0], vals_cur[1], vals_cur[2], vals_cur[3]};
		rsp_d.data_port      = {vals_cur[4], vals_cur[5]};
		rsp_d.field_overflow = ovf_cur;

		mp_d   = mp_cur;
		col_d  = col_cur;
		cnt_d  = cnt_cur;
		vals_d = vals_cur;
		ovf_d  = ovf_cur;
		emit   = 1'b0;

		if (!col_cur) begin
			if (fpasv_pkg::PREFIX_TEXT[pos] == ch) begin
				if (pos_inc >= fpasv_pkg::PREFIX_LEN_W) begin
					col_d = 1'b1;
					mp_d  = '0;
				end else begin
					mp_d = pos_inc;
				end
			end else if (ch == fpasv_pkg::CHAR_TWO) begin
				// fall back to the longest run of leading '2's
				mp_d = (pos == fpasv_pkg::POS_W'(2)) ? fpasv_pkg::POS_W'(2)
					: fpasv_pkg::POS_W'(1);
			end else begin
				mp_d = '0;
			end
		end else if (ch == fpasv_pkg::CHAR_COMMA) begin
			if (cnt_cur < fpasv_pkg::COUNTER_MAX) begin
				cnt_d = cnt_cur + fpasv_pkg::CNT_W'(1);
			end
		end else if (ch >= fpasv_pkg::CHAR_ZERO && ch <= fpasv_pkg::CHAR_NINE) begin
			// drop digits past the sixth number
			if (cnt_cur != '0 && cnt_cur <= fpasv_pkg::COUNTER_LAST) begin
				if (num_sum > fpasv_pkg::NUM_SAT_LIMIT) begin
					vals_d[cnt_idx] = 8'hFF;
					ovf_d = 1'b1;
				end else begin
					vals_d[cnt_idx] = num_sum[7:0];
				end
			end
		end else if (ch == fpasv_pkg::CHAR_CLOSE) begin
			emit   = 1'b1;
			mp_d   = '0;
			col_d  = 1'b0;
			cnt_d  = fpasv_pkg::COUNTER_INIT;
			vals_d = '{default: 8'h00};
			ovf_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			pasv_valid_q     <= 1'b0;
			match_position_q <= '0;
			collecting_q     <= 1'b0;
			number_counter_q <= fpasv_pkg::COUNTER_INIT;
			number_values_q  <= '{default: 8'h00};
			overflow_seen_q  <= 1'b0;
		end else begin
			if (!byte_stall) begin
				valid_s1 <= byte_valid;
			end
			if (out_free) begin
				pasv_valid_q <= proc && emit;
			end
			if (proc) begin
				match_position_q <= mp_d;
				collecting_q     <= col_d;
				number_counter_q <= cnt_d;
				number_values_q  <= vals_d;
				overflow_seen_q  <= ovf_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			req_s1 <= byte_item;
		end
		if (proc && emit) begin
			pasv_item_q <= rsp_d;
		end
	end

`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_counter_nonzero, number_counter_q != '0,
		"number counter left its 1..7 range")
	`ASSERT_ALWAYS(a_pos_in_prefix, match_position_q < fpasv_pkg::PREFIX_LEN_W,
		"match position ran past the prefix length")
	`ASSERT_ALWAYS(a_collect_pos_zero, !collecting_q || match_position_q == '0,
		"match position not cleared while collecting")
	`ASSERT_ALWAYS(a_stall_needs_item, valid_s1 || !byte_stall,
		"byte stall raised with an empty input register")
	`ASSERT_NEXT(a_clear_after_emit, proc && emit,
		!collecting_q && number_counter_q == fpasv_pkg::COUNTER_INIT && !overflow_seen_q,
		"parser not cleared after a result")

endmodule

@@ verif/tb_ftp_passive_reply_parser.sv @@
// Testbench for the FTP passive-mode reply parser: directed reply lines, random traffic, scoreboard.
`timescale 1ns / 1ps

module tb_ftp_passive_reply_parser;

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		string                text;
		int                   restart_at;
		bit                   typed;
		fpasv_pkg::pasv_rsp_t rsp;
	} reply_row_t;

	localparam logic [7:0] CHAR_OPEN = "(";
	localparam int BYTE_GOAL = 1600;

	logic                 clk;
	logic                 arst_n;
	logic                 byte_valid;
	logic                 byte_stall;
	fpasv_pkg::byte_req_t byte_item;
	logic                 pasv_valid;
	logic                 pasv_stall;
	fpasv_pkg::pasv_rsp_t pasv_item;

	// parser state as the checker sees it
	logic [4:0] match_pos;
	logic       in_numbers;
	logic [2:0] num_idx;
	logic [7:0] num_vals [fpasv_pkg::NUM_COUNT];
	logic       ovf_flag;

	fpasv_pkg::pasv_rsp_t endpoint_q[$];

	int src_idle_pct;
	int rcv_stall_pct;
	bit hold_go = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;
	int fail_count = 0;
	int bytes_sent;
	int lines_sent;
	int noise_lines;
	int endpoints_predicted;
	int endpoints_seen = 0;
	int overflow_results = 0;
	int input_held_cycles = 0;

	reply_row_t reply_rows[] = '{
		'{"227 Entering Passive Mode (255,0,0,1,255,255)", -1, 1'b1,
			'{32'hFF000001, 16'hFFFF, 1'b0}},
		'{"227 Entering Passive Mode (256,1000,0,0,0,9999)", -1, 1'b1,
			'{32'hFFFF0000, 16'h00FF, 1'b1}},
		'{"227 Entering Passive Mode ()", -1, 1'b1, '{32'h0, 16'h0, 1'b0}},
		'{"2227 Entering Passive Mode (10,20)", -1, 1'b0, '{32'h0, 16'h0, 1'b0}},
		'{"227 Enter2227 Entering Passive Mode (1,2,3,4,5,6)", -1, 1'b0,
			'{32'h0, 16'h0, 1'b0}},
		'{"22227 Entering Passive Mode x(192,0,2,7,80,1)x", -1, 1'b0,
			'{32'h0, 16'h0, 1'b0}},
		'{"227 Entering Passive Mode ( 1 ,\377 2,a3,4,5 ,6,7,8,9)", -1, 1'b0,
			'{32'h0, 16'h0, 1'b0}},
		'{"227 Entering Passive Mode (1,2,3,4,5,6,,,,,,,,,99)", -1, 1'b0,
			'{32'h0, 16'h0, 1'b0}},
		'{")(1,2)227 Entering Passive Mode 227 Entering Passive Mode (7,8,9)", -1, 1'b0,
			'{32'h0, 16'h0, 1'b0}},
		'{"227 Entering Passive Mode (1,2,3", -1, 1'b0, '{32'h0, 16'h0, 1'b0}},
		'{"4,5)", 0, 1'b0, '{32'h0, 16'h0, 1'b0}},
		'{"227 Entering Passive Mode (9,8,7,6,5,4)", 0, 1'b1,
			'{32'h09080706, 16'h0504, 1'b0}},
		'{"227 Entering Passive Mod(3,3)", -1, 1'b0, '{32'h0, 16'h0, 1'b0}}
	};

	ftp_passive_reply_parser DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.pasv_valid (pasv_valid),
		.pasv_stall (pasv_stall),
		.pasv_item  (pasv_item)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("** ftp_passive_reply_parser: FAILED **");
		$finish;
	end

	function automatic void clear_parser();
		match_pos = '0;
		in_numbers = 1'b0;
		num_idx = fpasv_pkg::COUNTER_INIT;
		for (int i = 0; i < fpasv_pkg::NUM_COUNT; i++) num_vals[i] = '0;
		ovf_flag = 1'b0;
	endfunction

	// Advance the parser by one request; return 1 when a ')' closes the number list.
	function automatic bit decode_reply_byte(input fpasv_pkg::byte_req_t req,
		output fpasv_pkg::pasv_rsp_t rsp);
		logic [4:0]  pos;
		logic [11:0] acc;
		logic [7:0]  c;
		c = req.reply_byte;
		rsp = '0;
		if (req.restart) clear_parser();
		if (!in_numbers) begin
			pos = match_pos;
			if (pos >= fpasv_pkg::PREFIX_LEN_EFF) pos = '0;
			if (fpasv_pkg::PREFIX_TEXT[pos] == c) begin
				pos = pos + 5'd1;
				if (pos >= fpasv_pkg::PREFIX_LEN_EFF) begin
					in_numbers = 1'b1;
					pos = '0;
				end
			end else if (c == fpasv_pkg::CHAR_TWO) begin
				// fall back: "22" still matches the head of the prefix
				pos = (pos == 5'd2) ? 5'd2 : 5'd1;
			end else begin
				pos = '0;
			end
			match_pos = pos;
			return 1'b0;
		end
		if (c == fpasv_pkg::CHAR_COMMA) begin
			if (num_idx < fpasv_pkg::COUNTER_MAX) num_idx = num_idx + 3'd1;
			return 1'b0;
		end
		if (c >= fpasv_pkg::CHAR_ZERO && c <= fpasv_pkg::CHAR_NINE) begin
			if (num_idx >= fpasv_pkg::COUNTER_INIT && num_idx <= fpasv_pkg::COUNTER_LAST) begin
				acc = 12'(num_vals[num_idx - 3'd1]) * 12'd10
					+ 12'(c - fpasv_pkg::CHAR_ZERO);
				if (acc > fpasv_pkg::NUM_SAT_LIMIT) begin
					acc = fpasv_pkg::NUM_SAT_LIMIT;
					ovf_flag = 1'b1;
				end
				num_vals[num_idx - 3'd1] = acc[7:0];
			end
			return 1'b0;
		end
		if (c == fpasv_pkg::CHAR_CLOSE) begin
			rsp.host_address = {num_vals[0], num_vals[1], num_vals[2], num_vals[3]};
			rsp.data_port = {num_vals[4], num_vals[5]};
			rsp.field_overflow = ovf_flag;
			clear_parser();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Offer one request and hold it until the parser takes it.
	task automatic push_byte(input fpasv_pkg::byte_req_t req);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= req;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
	endtask

	task automatic send_line(input byte_q_t line, input int restart_at, input bit typed,
		input fpasv_pkg::pasv_rsp_t typed_rsp);
		fpasv_pkg::byte_req_t req;
		fpasv_pkg::pasv_rsp_t rsp;
		bit                   got;
		for (int i = 0; i < line.size(); i++) begin
			req.reply_byte = line[i];
			req.restart = (i == restart_at);
			push_byte(req);
			bytes_sent++;
			got = decode_reply_byte(req, rsp);
			if (got) begin
				endpoint_q.push_back(typed ? typed_rsp : rsp);
				endpoints_predicted++;
			end
		end
		lines_sent++;
	endtask

	// Mostly well-formed replies with random numbers; some cut prefixes and raw noise.
	function automatic void build_random_line(output byte_q_t line, output bit is_noise);
		int    kind;
		int    cut;
		int    n_nums;
		int    v;
		string digits;
		line = {};
		is_noise = 1'b0;
		kind = $urandom_range(0, 9);
		if (kind == 9) begin
			is_noise = 1'b1;
			repeat ($urandom_range(1, 24)) line.push_back(8'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(0, 3))
			line.push_back($urandom_range(0, 1) ? fpasv_pkg::CHAR_TWO
				: 8'($urandom_range(32, 126)));
		cut = (kind == 8) ? $urandom_range(1, fpasv_pkg::PREFIX_LEN_EFF - 1)
			: fpasv_pkg::PREFIX_LEN_EFF;
		for (int i = 0; i < cut; i++) line.push_back(fpasv_pkg::PREFIX_TEXT[i]);
		if (kind == 8) line.push_back(8'($urandom_range(0, 255)));
		line.push_back(CHAR_OPEN);
		n_nums = ($urandom_range(0, 7) != 0) ? fpasv_pkg::NUM_COUNT : $urandom_range(0, 9);
		for (int k = 0; k < n_nums; k++) begin
			if (k != 0) line.push_back(fpasv_pkg::CHAR_COMMA);
			v = ($urandom_range(0, 15) == 0) ? $urandom_range(256, 9999) : $urandom_range(0, 255);
			if ($urandom_range(0, 9) == 0) line.push_back(fpasv_pkg::CHAR_ZERO);
			digits = $sformatf("%0d", v);
			for (int j = 0; j < digits.len(); j++) line.push_back(digits[j]);
			if ($urandom_range(0, 19) == 0) line.push_back(8'($urandom_range(0, 255)));
		end
		line.push_back(fpasv_pkg::CHAR_CLOSE);
	endfunction

	// receiver side: random stall, or a long hold-off counted down here once requested
	always @(negedge clk) begin
		if (hold_go && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			pasv_stall <= 1'b1;
		end else begin
			pasv_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
		end
	end

	always @(posedge clk) begin : endpoint_check
		fpasv_pkg::pasv_rsp_t want;
		if (arst_n && byte_valid && byte_stall) input_held_cycles++;
		if (arst_n && pasv_valid && !pasv_stall) begin
			if (endpoint_q.size() == 0) begin
				$error("unexpected result: host_address=%h data_port=%h field_overflow=%b",
					pasv_item.host_address, pasv_item.data_port, pasv_item.field_overflow);
				fail_count++;
			end else begin
				want = endpoint_q.pop_front();
				if (pasv_item.host_address !== want.host_address) begin
					$error("host_address: expected %h, got %h",
						want.host_address, pasv_item.host_address);
					fail_count++;
				end
				if (pasv_item.data_port !== want.data_port) begin
					$error("data_port: expected %h, got %h", want.data_port, pasv_item.data_port);
					fail_count++;
				end
				if (pasv_item.field_overflow !== want.field_overflow) begin
					$error("field_overflow: expected %b, got %b",
						want.field_overflow, pasv_item.field_overflow);
					fail_count++;
				end
				if (want.field_overflow) overflow_results++;
				endpoints_seen++;
			end
		end
	end

	initial begin
		byte_q_t line;
		bit      is_noise;
		int      restart_at;
		int      phase;
		int      drain;
		int      rand_lines;
		int      missing;
		string   s;

		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_item = '0;
		src_idle_pct = 0;
		rcv_stall_pct = 0;
		bytes_sent = 0;
		lines_sent = 0;
		noise_lines = 0;
		endpoints_predicted = 0;
		rand_lines = 0;
		missing = 0;
		clear_parser();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		src_idle_pct = 7;
		rcv_stall_pct = 7;
		foreach (reply_rows[r]) begin
			s = reply_rows[r].text;
			line = {};
			for (int i = 0; i < s.len(); i++) line.push_back(s[i]);
			send_line(line, reply_rows[r].restart_at, reply_rows[r].typed, reply_rows[r].rsp);
		end

		while (bytes_sent < BYTE_GOAL) begin
			phase = (rand_lines / 5) % 4;
			src_idle_pct = (phase == 1) ? 71 : (phase == 3) ? 7 : 0;
			rcv_stall_pct = (phase == 2) ? 71 : (phase == 3) ? 7 : 0;
			// hold off the receiver long enough that a result backs up into the input
			if (rand_lines == 2) hold_go = 1'b1;
			build_random_line(line, is_noise);
			case ($urandom_range(0, 19))
				0: restart_at = 0;
				1: restart_at = $urandom_range(0, line.size() - 1);
				default: restart_at = -1;
			endcase
			send_line(line, restart_at, 1'b0, '0);
			if (is_noise) noise_lines++;
			rand_lines++;
		end

		@(negedge clk);
		byte_valid <= 1'b0;
		rcv_stall_pct = 0;
		drain = 0;
		while (endpoint_q.size() != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (8) @(posedge clk);
		missing = endpoint_q.size();
		if (missing != 0) begin
			$error("%0d expected results never arrived", missing);
		end

		$display("Sent %0d reply lines (%0d random, %0d noise), %0d bytes; %0d endpoints",
			lines_sent, rand_lines, noise_lines, bytes_sent, endpoints_seen);
		$display("checked, %0d with overflow; input back-pressure held for %0d cycles.",
			overflow_results, input_held_cycles);
		if (fail_count == 0 && missing == 0) begin
			$display("** ftp_passive_reply_parser: PASSED **");
		end else begin
			$display("** ftp_passive_reply_parser: FAILED **");
		end
		$finish;
	end

endmodule
